[rtl/cse_pkg.sv]
package cse_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int ACC_WIDTH  = 44;
   localparam int SIM_WIDTH  = 16;
   localparam int SQ_WIDTH   = 2 * ELEM_WIDTH;
   localparam int PAIR_WIDTH = 2 * ACC_WIDTH;
   localparam int PROD_WIDTH = PAIR_WIDTH + SQ_WIDTH;
   localparam int K_WIDTH    = SIM_WIDTH;

   // controller to datapath commands
   typedef struct packed {
      logic accum;
      logic load_p;
      logic load_r;
      logic load_s;
      logic mul_step;
      logic store_p;
      logic store_r;
      logic search_init;
      logic search_update;
      logic clear;
   } cse_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mul_done;
      logic search_done;
      logic zero_mag;
   } cse_status_type;

endpackage

[rtl/cse_datapath.sv]
module cse_datapath import cse_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cse_cmd_type                   cmd,
   input  logic signed [ELEM_WIDTH-1:0]  elem_a,
   input  logic signed [ELEM_WIDTH-1:0]  elem_b,
   output cse_status_type                status,
   output logic signed [SIM_WIDTH-1:0]   similarity,
   output logic                          zero_magnitude
);

   logic signed [ACC_WIDTH-1:0]  dot_ff, dot_in;
   logic [ACC_WIDTH-1:0]         mag_a_ff, mag_a_in;
   logic [ACC_WIDTH-1:0]         mag_b_ff, mag_b_in;
   logic signed [SQ_WIDTH-1:0]   prod_ab;
   logic [SQ_WIDTH-1:0]          sq_a, sq_b;
   logic signed [ACC_WIDTH:0]    dot_sum;
   logic [ACC_WIDTH:0]           mag_a_sum, mag_b_sum;

   logic [PROD_WIDTH-1:0]        mcand_ff, prod_ff;
   logic [ACC_WIDTH-1:0]         mplier_ff;
   logic [PAIR_WIDTH-1:0]        p_ff, r_ff;
   logic [ACC_WIDTH-1:0]         dot_abs;
   logic [K_WIDTH-1:0]           lo_ff, hi_ff;
   logic [K_WIDTH:0]             k_sum;
   logic [K_WIDTH-1:0]           k_mid, odd;
   logic [SQ_WIDTH-1:0]          odd_sq;
   logic                         fits;

   // saturating accumulation of one element pair
   always_comb begin
      prod_ab   = elem_a * elem_b;
      sq_a      = SQ_WIDTH'(elem_a * elem_a);
      sq_b      = SQ_WIDTH'(elem_b * elem_b);
      dot_sum   = {dot_ff[ACC_WIDTH-1], dot_ff}
                + {{(ACC_WIDTH+1-SQ_WIDTH){prod_ab[SQ_WIDTH-1]}}, prod_ab};
      mag_a_sum = {1'b0, mag_a_ff} + {{(ACC_WIDTH+1-SQ_WIDTH){1'b0}}, sq_a};
      mag_b_sum = {1'b0, mag_b_ff} + {{(ACC_WIDTH+1-SQ_WIDTH){1'b0}}, sq_b};
      dot_in = dot_sum[ACC_WIDTH-1:0];
      if (dot_sum[ACC_WIDTH] != dot_sum[ACC_WIDTH-1]) begin
         dot_in = dot_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      mag_a_in = mag_a_sum[ACC_WIDTH] ? '1 : mag_a_sum[ACC_WIDTH-1:0];
      mag_b_in = mag_b_sum[ACC_WIDTH] ? '1 : mag_b_sum[ACC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         dot_ff   <= '0;
         mag_a_ff <= '0;
         mag_b_ff <= '0;
      end else if (cmd.accum) begin
         dot_ff   <= dot_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
      end
   end

   // search midpoint and odd square for the rounding test
   always_comb begin
      dot_abs = dot_ff[ACC_WIDTH-1] ? ACC_WIDTH'(0 - dot_ff) : ACC_WIDTH'(dot_ff);
      k_sum   = {1'b0, lo_ff} + {1'b0, hi_ff} + {{K_WIDTH{1'b0}}, 1'b1};
      k_mid   = k_sum[K_WIDTH:1];
      odd     = K_WIDTH'({k_mid, 1'b0} - {{K_WIDTH{1'b0}}, 1'b1});
      odd_sq  = odd * odd;
      fits    = prod_ff <= {r_ff, {SQ_WIDTH{1'b0}}};
   end

   // shift-add multiplier, one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.load_p) begin
         mcand_ff  <= {{(PROD_WIDTH-ACC_WIDTH){1'b0}}, mag_a_ff};
         mplier_ff <= mag_b_ff;
         prod_ff   <= '0;
      end else if (cmd.load_r) begin
         mcand_ff  <= {{(PROD_WIDTH-ACC_WIDTH){1'b0}}, dot_abs};
         mplier_ff <= dot_abs;
         prod_ff   <= '0;
      end else if (cmd.load_s) begin
         mcand_ff  <= {{SQ_WIDTH{1'b0}}, p_ff};
         mplier_ff <= {{(ACC_WIDTH-SQ_WIDTH){1'b0}}, odd_sq};
         prod_ff   <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[PROD_WIDTH-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[ACC_WIDTH-1:1]};
      end
   end

   // hold products and search bounds
   always_ff @(posedge clock) begin
      if (cmd.store_p) begin
         p_ff <= prod_ff[PAIR_WIDTH-1:0];
      end
      if (cmd.store_r) begin
         r_ff <= prod_ff[PAIR_WIDTH-1:0];
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= {1'b1, {(K_WIDTH-1){1'b0}}};
      end else if (cmd.search_update) begin
         if (fits) begin
            lo_ff <= k_mid;
         end else begin
            hi_ff <= K_WIDTH'(k_mid - {{(K_WIDTH-1){1'b0}}, 1'b1});
         end
      end
   end

   // form the status flags and the result from the settled bound
   always_comb begin
      status.mul_done    = (mplier_ff == '0);
      status.search_done = (lo_ff >= hi_ff);
      status.zero_mag    = (mag_a_ff == '0) || (mag_b_ff == '0);
      zero_magnitude     = status.zero_mag;
      if (status.zero_mag) begin
         similarity = '0;
      end else if (dot_ff[ACC_WIDTH-1]) begin
         similarity = SIM_WIDTH'(0 - lo_ff);
      end else if (lo_ff[K_WIDTH-1]) begin
         similarity = {1'b0, {(SIM_WIDTH-1){1'b1}}};
      end else begin
         similarity = SIM_WIDTH'(lo_ff);
      end
   end

endmodule

[rtl/cse_ctrl.sv]
module cse_ctrl import cse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           accept_last,
   input  logic           out_free,
   input  cse_status_type status,
   output cse_cmd_type    cmd,
   output logic           busy,
   output logic           out_load
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_MUL_P  = 3'd2;
   localparam logic [2:0] S_MUL_R  = 3'd3;
   localparam logic [2:0] S_SEARCH = 3'd4;
   localparam logic [2:0] S_MUL_S  = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            cmd.accum = accept;
            if (accept_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.zero_mag) begin
               state_in = S_OUT;
            end else begin
               cmd.load_p = 1'b1;
               state_in   = S_MUL_P;
            end
         end
         S_MUL_P: begin
            if (status.mul_done) begin
               cmd.store_p = 1'b1;
               cmd.load_r  = 1'b1;
               state_in    = S_MUL_R;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_MUL_R: begin
            if (status.mul_done) begin
               cmd.store_r     = 1'b1;
               cmd.search_init = 1'b1;
               state_in        = S_SEARCH;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_SEARCH: begin
            if (status.search_done) begin
               state_in = S_OUT;
            end else begin
               cmd.load_s = 1'b1;
               state_in   = S_MUL_S;
            end
         end
         S_MUL_S: begin
            if (status.mul_done) begin
               cmd.search_update = 1'b1;
               state_in          = S_SEARCH;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_load  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/cosine_similarity_engine.sv]
// Accumulation: one element pair per cycle, no stall on beats with last low.
// A last beat runs the final ratio on a shared shift-add multiplier: first for
// magA*magB and dot^2, then for up to 16 search steps; a zero magnitude skips
// the multiplier and goes straight to the output. Input stalls until the
// result is loaded for output. Synchronous active-high reset clears the
// accumulators, the controller and the output valid.
module cosine_similarity_engine import cse_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ELEM_WIDTH-1:0]  req_elem_a,
   input  logic signed [ELEM_WIDTH-1:0]  req_elem_b,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SIM_WIDTH-1:0]   rsp_similarity,
   output logic                          rsp_zero_magnitude
);

   cse_cmd_type              cmd;
   cse_status_type           status;
   logic                     busy, out_load, out_free, accept;
   logic signed [SIM_WIDTH-1:0] sim;
   logic                     zmag;
   logic                     rsp_valid_ff;
   logic signed [SIM_WIDTH-1:0] rsp_sim_ff;
   logic                     rsp_zero_ff;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   cse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .accept_last (accept && req_last),
      .out_free    (out_free),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .out_load    (out_load)
   );

   cse_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .elem_a         (req_elem_a),
      .elem_b         (req_elem_b),
      .status         (status),
      .similarity     (sim),
      .zero_magnitude (zmag)
   );

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sim_ff  <= sim;
         rsp_zero_ff <= zmag;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_similarity     = rsp_sim_ff;
   assign rsp_zero_magnitude = rsp_zero_ff;

   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_magnitude |-> rsp_similarity == '0)
      else $error("zero magnitude beat with nonzero similarity");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input not stalled after last beat");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded over a pending beat");

endmodule
